[design/stl_pkg.sv]
// Shared types, token kinds and character codes of the script token lexer.
// No dependencies; used by stl_core, stl_outq and script_token_lexer.
package stl_pkg;

    // Class of the token held in progress; codes 7 mean nothing and act as idle.
    typedef enum logic [2:0] {
        CL_IDLE  = 3'd0,
        CL_ID    = 3'd1,
        CL_NUM   = 3'd2,
        CL_PLUS  = 3'd3,
        CL_MINUS = 3'd4,
        CL_STAR  = 3'd5,
        CL_SLASH = 3'd6
    } t_class;

    typedef enum logic [3:0] {
        K_ID      = 4'd0,
        K_INT     = 4'd1,
        K_FLOAT   = 4'd2,
        K_DOT     = 4'd3,
        K_PLUS    = 4'd4,
        K_PLUS2   = 4'd5,
        K_PLUSEQ  = 4'd6,
        K_MINUS   = 4'd7,
        K_MINUS2  = 4'd8,
        K_MINUSEQ = 4'd9,
        K_STAR    = 4'd10,
        K_STAREQ  = 4'd11,
        K_SLASH   = 4'd12,
        K_SLASHEQ = 4'd13,
        K_INVALID = 4'd14,
        K_END     = 4'd15
    } t_kind;

    localparam int KIND_BITS = 4;
    localparam int MAX_RESULTS = 3;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_POINT = 8'h2E;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;

    // Results handed from the lexing core to the output queue for one item.
    typedef struct packed {
        logic       push;
        logic [1:0] count;
    } t_push_ctl;

    function automatic logic f_is_letter(input logic [7:0] c);
        f_is_letter = (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
    endfunction

    function automatic logic f_is_digit(input logic [7:0] c);
        f_is_digit = (c >= 8'h30 && c <= 8'h39);
    endfunction

endpackage

[design/script_token_lexer.sv]
// Script token lexer: one source byte per item in, tokens out.
// The tokens of an item are registered in the result queue, then in the output register.
// Throughput: one item per clock while each gives at most one token and the output is free; an
// item with more holds the input until its last token enters the one-token output register.
// Reset (i_rst_n low, synchronous): line 1, column 1, offset 0, no token pending, queue empty.
// Depends on stl_pkg, stl_core and stl_outq.
module script_token_lexer #(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 16,
    parameter int OFFSET_BITS = 24,
    parameter int LENGTH_BITS = 16,
    localparam int TOK_W = stl_pkg::KIND_BITS + LINE_BITS + COLUMN_BITS
                         + OFFSET_BITS + LENGTH_BITS + 2,
    localparam int OUT_W = ((TOK_W - stl_pkg::KIND_BITS + 7) / 8) * 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input items
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,   // char_byte
    input  logic                          i_s_axis_tuser,   // char_valid
    input  logic                          i_s_axis_tlast,   // is_final
    // token items
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    // start_line, start_column, start_offset, token_length,
    // add_leading_zero, add_trailing_zero, zero fill
    output logic [OUT_W-1:0]              o_m_axis_tdata,
    output logic [stl_pkg::KIND_BITS-1:0] o_m_axis_tuser,   // token_kind
    output logic                          o_m_axis_tlast    // end_of_run
);

    stl_pkg::t_push_ctl push;
    logic [TOK_W-1:0]   tok [stl_pkg::MAX_RESULTS];
    logic               can_take;
    logic               accept;
    logic [TOK_W-1:0]   out_tok;

    // Take an item whenever the queue will be free of the previous item's tokens.
    assign o_s_axis_tready = can_take;
    assign accept          = i_s_axis_tvalid && can_take;

    // Classify the byte, update counters and build this item's tokens.
    stl_core #(
        .LINE_BITS   (LINE_BITS),
        .COLUMN_BITS (COLUMN_BITS),
        .OFFSET_BITS (OFFSET_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (accept),
        .i_char       (i_s_axis_tdata),
        .i_char_valid (i_s_axis_tuser),
        .i_final      (i_s_axis_tlast),
        .o_push       (push),
        .o_tok        (tok)
    );

    // Hold tokens, hand out one per clock unless output stalls; tlast marks an item's last token.
    stl_outq #(
        .TOK_W (TOK_W)
    ) u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_tok      (tok),
        .o_can_take (can_take),
        .o_valid    (o_m_axis_tvalid),
        .i_ready    (i_m_axis_tready),
        .o_tok      (out_tok),
        .o_last     (o_m_axis_tlast)
    );

    // Split the token: kind goes out on tuser, the position fields on tdata.
    assign o_m_axis_tuser = out_tok[stl_pkg::KIND_BITS-1:0];
    assign o_m_axis_tdata = OUT_W'(out_tok[TOK_W-1:stl_pkg::KIND_BITS]);

endmodule

[design/stl_core.sv]
// Lexing core: position counters, pending token state and up to three
// result tokens per item, the tokens built combinationally. Depends on stl_pkg.
module stl_core #(
    parameter int LINE_BITS   = 16,
    parameter int COLUMN_BITS = 16,
    parameter int OFFSET_BITS = 24,
    parameter int LENGTH_BITS = 16,
    localparam int TOK_W = stl_pkg::KIND_BITS + LINE_BITS + COLUMN_BITS
                         + OFFSET_BITS + LENGTH_BITS + 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [7:0]            i_char,
    input  logic                  i_char_valid,
    input  logic                  i_final,
    output stl_pkg::t_push_ctl    o_push,
    output logic [TOK_W-1:0]      o_tok [stl_pkg::MAX_RESULTS]
);

    stl_pkg::t_class          r_cls, n_cls;
    logic                     r_seen_point, n_seen_point;
    logic                     r_seen_digit, n_seen_digit;
    logic                     r_first_pt, n_first_pt;
    logic                     r_last_pt, n_last_pt;
    logic [LINE_BITS-1:0]     r_cur_line, n_cur_line;
    logic [COLUMN_BITS-1:0]   r_cur_col, n_cur_col;
    logic [OFFSET_BITS-1:0]   r_cur_off, n_cur_off;
    logic [LINE_BITS-1:0]     r_pend_line, n_pend_line;
    logic [COLUMN_BITS-1:0]   r_pend_col, n_pend_col;
    logic [OFFSET_BITS-1:0]   r_pend_off, n_pend_off;
    logic [LENGTH_BITS-1:0]   r_pend_len, n_pend_len;

    logic [TOK_W-1:0]         res [stl_pkg::MAX_RESULTS];
    logic [1:0]               cnt;
    logic                     used;
    logic [OFFSET_BITS-1:0]   inv_off;
    logic [TOK_W:0]           fl;

    function automatic logic [TOK_W-1:0] f_pack(
        input stl_pkg::t_kind         kind,
        input logic [LINE_BITS-1:0]   line,
        input logic [COLUMN_BITS-1:0] col,
        input logic [OFFSET_BITS-1:0] off,
        input logic [LENGTH_BITS-1:0] len,
        input logic                   lz,
        input logic                   tz
    );
        f_pack = {tz, lz, len, off, col, line, kind};
    endfunction

    // Token for whatever is pending; top bit says whether one exists.
    function automatic logic [TOK_W:0] f_flush(
        input stl_pkg::t_class        cls,
        input logic                   sp,
        input logic                   sd,
        input logic                   fp,
        input logic                   lp,
        input logic [LINE_BITS-1:0]   line,
        input logic [COLUMN_BITS-1:0] col,
        input logic [OFFSET_BITS-1:0] off,
        input logic [LENGTH_BITS-1:0] len
    );
        stl_pkg::t_kind kind;
        logic           hit;
        logic           lz;
        logic           tz;
        hit  = 1'b1;
        lz   = 1'b0;
        tz   = 1'b0;
        kind = stl_pkg::K_ID;
        case (cls)
            stl_pkg::CL_ID: begin
                kind = stl_pkg::K_ID;
            end
            stl_pkg::CL_NUM: begin
                if (sp && !sd) begin
                    kind = stl_pkg::K_DOT;
                end else if (sp) begin
                    kind = stl_pkg::K_FLOAT;
                    lz   = fp;
                    tz   = !fp && lp;
                end else begin
                    kind = stl_pkg::K_INT;
                end
            end
            stl_pkg::CL_PLUS:  kind = stl_pkg::K_PLUS;
            stl_pkg::CL_MINUS: kind = stl_pkg::K_MINUS;
            stl_pkg::CL_STAR:  kind = stl_pkg::K_STAR;
            stl_pkg::CL_SLASH: kind = stl_pkg::K_SLASH;
            default:           hit  = 1'b0;
        endcase
        f_flush = {hit, f_pack(kind, line, col, off, len, lz, tz)};
    endfunction

    always_comb begin
        n_cls        = r_cls;
        n_seen_point = r_seen_point;
        n_seen_digit = r_seen_digit;
        n_first_pt   = r_first_pt;
        n_last_pt    = r_last_pt;
        n_cur_line   = r_cur_line;
        n_cur_col    = r_cur_col;
        n_cur_off    = r_cur_off;
        n_pend_line  = r_pend_line;
        n_pend_col   = r_pend_col;
        n_pend_off   = r_pend_off;
        n_pend_len   = r_pend_len;
        for (int k = 0; k < stl_pkg::MAX_RESULTS; k++) begin
            res[k] = '0;
        end
        cnt     = 2'd0;
        used    = 1'b0;
        inv_off = r_cur_off;
        fl      = '0;

        if (i_char_valid) begin
            // Try to grow the pending token first.
            case (r_cls)
                stl_pkg::CL_ID: begin
                    used = stl_pkg::f_is_letter(i_char) || stl_pkg::f_is_digit(i_char)
                        || i_char == stl_pkg::CH_USCORE;
                end
                stl_pkg::CL_NUM: begin
                    if (stl_pkg::f_is_digit(i_char)) begin
                        used         = 1'b1;
                        n_seen_digit = 1'b1;
                        n_last_pt    = 1'b0;
                    end else if (i_char == stl_pkg::CH_POINT && !r_seen_point) begin
                        used         = 1'b1;
                        n_seen_point = 1'b1;
                        n_last_pt    = 1'b1;
                    end
                end
                stl_pkg::CL_PLUS: begin
                    if (i_char == stl_pkg::CH_PLUS || i_char == stl_pkg::CH_EQ) begin
                        used = 1'b1;
                        res[0] = f_pack((i_char == stl_pkg::CH_PLUS) ? stl_pkg::K_PLUS2
                            : stl_pkg::K_PLUSEQ, r_pend_line, r_pend_col, r_pend_off,
                            (r_pend_len == '1) ? r_pend_len : r_pend_len + 1'b1,
                            1'b0, 1'b0);
                        cnt   = 2'd1;
                        n_cls = stl_pkg::CL_IDLE;
                    end
                end
                stl_pkg::CL_MINUS: begin
                    if (i_char == stl_pkg::CH_MINUS || i_char == stl_pkg::CH_EQ) begin
                        used = 1'b1;
                        res[0] = f_pack((i_char == stl_pkg::CH_MINUS) ? stl_pkg::K_MINUS2
                            : stl_pkg::K_MINUSEQ, r_pend_line, r_pend_col, r_pend_off,
                            (r_pend_len == '1) ? r_pend_len : r_pend_len + 1'b1,
                            1'b0, 1'b0);
                        cnt   = 2'd1;
                        n_cls = stl_pkg::CL_IDLE;
                    end
                end
                stl_pkg::CL_STAR, stl_pkg::CL_SLASH: begin
                    if (i_char == stl_pkg::CH_EQ) begin
                        used = 1'b1;
                        res[0] = f_pack((r_cls == stl_pkg::CL_STAR) ? stl_pkg::K_STAREQ
                            : stl_pkg::K_SLASHEQ, r_pend_line, r_pend_col, r_pend_off,
                            (r_pend_len == '1) ? r_pend_len : r_pend_len + 1'b1,
                            1'b0, 1'b0);
                        cnt   = 2'd1;
                        n_cls = stl_pkg::CL_IDLE;
                    end
                end
                default: used = 1'b0;
            endcase

            if (used) begin
                n_pend_len = (r_pend_len == '1) ? r_pend_len : r_pend_len + 1'b1;
                n_cur_col  = (r_cur_col == '1) ? r_cur_col : r_cur_col + 1'b1;
                n_cur_off  = (r_cur_off == '1) ? r_cur_off : r_cur_off + 1'b1;
            end else begin
                // Close the pending token, then treat the byte from scratch.
                fl = f_flush(r_cls, r_seen_point, r_seen_digit, r_first_pt, r_last_pt,
                             r_pend_line, r_pend_col, r_pend_off, r_pend_len);
                if (fl[TOK_W]) begin
                    res[0] = fl[TOK_W-1:0];
                    cnt    = 2'd1;
                end
                n_cls = stl_pkg::CL_IDLE;

                if (i_char == stl_pkg::CH_SPACE || i_char == stl_pkg::CH_TAB) begin
                    n_cur_col = (r_cur_col == '1) ? r_cur_col : r_cur_col + 1'b1;
                    n_cur_off = (r_cur_off == '1) ? r_cur_off : r_cur_off + 1'b1;
                end else if (i_char == stl_pkg::CH_NL) begin
                    n_cur_line = (r_cur_line == '1) ? r_cur_line : r_cur_line + 1'b1;
                    n_cur_col  = COLUMN_BITS'(1);
                    n_cur_off  = (r_cur_off == '1) ? r_cur_off : r_cur_off + 1'b1;
                end else if (stl_pkg::f_is_letter(i_char) || stl_pkg::f_is_digit(i_char)
                             || i_char == stl_pkg::CH_USCORE || i_char == stl_pkg::CH_POINT
                             || i_char == stl_pkg::CH_PLUS || i_char == stl_pkg::CH_MINUS
                             || i_char == stl_pkg::CH_STAR || i_char == stl_pkg::CH_SLASH) begin
                    n_pend_line = r_cur_line;
                    n_pend_col  = r_cur_col;
                    n_pend_off  = r_cur_off;
                    n_pend_len  = LENGTH_BITS'(1);
                    n_cur_col   = (r_cur_col == '1) ? r_cur_col : r_cur_col + 1'b1;
                    n_cur_off   = (r_cur_off == '1) ? r_cur_off : r_cur_off + 1'b1;
                    if (stl_pkg::f_is_digit(i_char) || i_char == stl_pkg::CH_POINT) begin
                        n_cls        = stl_pkg::CL_NUM;
                        n_seen_point = (i_char == stl_pkg::CH_POINT);
                        n_seen_digit = (i_char != stl_pkg::CH_POINT);
                        n_first_pt   = (i_char == stl_pkg::CH_POINT);
                        n_last_pt    = (i_char == stl_pkg::CH_POINT);
                    end else if (i_char == stl_pkg::CH_PLUS) begin
                        n_cls = stl_pkg::CL_PLUS;
                    end else if (i_char == stl_pkg::CH_MINUS) begin
                        n_cls = stl_pkg::CL_MINUS;
                    end else if (i_char == stl_pkg::CH_STAR) begin
                        n_cls = stl_pkg::CL_STAR;
                    end else if (i_char == stl_pkg::CH_SLASH) begin
                        n_cls = stl_pkg::CL_SLASH;
                    end else begin
                        n_cls = stl_pkg::CL_ID;
                    end
                end else begin
                    // Invalid byte: column reported after advancing.
                    inv_off   = r_cur_off;
                    n_cur_col = (r_cur_col == '1) ? r_cur_col : r_cur_col + 1'b1;
                    n_cur_off = (r_cur_off == '1) ? r_cur_off : r_cur_off + 1'b1;
                    res[cnt]  = f_pack(stl_pkg::K_INVALID, r_cur_line, n_cur_col, inv_off,
                                       LENGTH_BITS'(1), 1'b0, 1'b0);
                    cnt       = cnt + 2'd1;
                end
            end
        end

        if (i_final) begin
            fl = f_flush(n_cls, n_seen_point, n_seen_digit, n_first_pt, n_last_pt,
                         n_pend_line, n_pend_col, n_pend_off, n_pend_len);
            if (fl[TOK_W]) begin
                res[cnt] = fl[TOK_W-1:0];
                cnt      = cnt + 2'd1;
            end
            res[cnt] = f_pack(stl_pkg::K_END, n_cur_line, n_cur_col, n_cur_off,
                              '0, 1'b0, 1'b0);
            cnt      = cnt + 2'd1;
            // End of source: return to the reset state.
            n_cls        = stl_pkg::CL_IDLE;
            n_seen_point = 1'b0;
            n_seen_digit = 1'b0;
            n_first_pt   = 1'b0;
            n_last_pt    = 1'b0;
            n_cur_line   = LINE_BITS'(1);
            n_cur_col    = COLUMN_BITS'(1);
            n_cur_off    = '0;
            n_pend_line  = LINE_BITS'(1);
            n_pend_col   = COLUMN_BITS'(1);
            n_pend_off   = '0;
            n_pend_len   = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cls        <= stl_pkg::CL_IDLE;
            r_seen_point <= 1'b0;
            r_seen_digit <= 1'b0;
            r_first_pt   <= 1'b0;
            r_last_pt    <= 1'b0;
            r_cur_line   <= LINE_BITS'(1);
            r_cur_col    <= COLUMN_BITS'(1);
            r_cur_off    <= '0;
            r_pend_line  <= LINE_BITS'(1);
            r_pend_col   <= COLUMN_BITS'(1);
            r_pend_off   <= '0;
            r_pend_len   <= '0;
        end else if (i_accept) begin
            r_cls        <= n_cls;
            r_seen_point <= n_seen_point;
            r_seen_digit <= n_seen_digit;
            r_first_pt   <= n_first_pt;
            r_last_pt    <= n_last_pt;
            r_cur_line   <= n_cur_line;
            r_cur_col    <= n_cur_col;
            r_cur_off    <= n_cur_off;
            r_pend_line  <= n_pend_line;
            r_pend_col   <= n_pend_col;
            r_pend_off   <= n_pend_off;
            r_pend_len   <= n_pend_len;
        end
    end

    assign o_push.push  = i_accept;
    assign o_push.count = cnt;
    assign o_tok        = res;

    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && i_final |=> r_cls == stl_pkg::CL_IDLE && r_cur_line == LINE_BITS'(1)
            && r_cur_off == '0)
        else $error("state not cleared after end of source");

    a_pending_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cls != stl_pkg::CL_IDLE && r_cls != 3'd7) |-> r_pend_len != '0)
        else $error("pending token with zero length");

    a_pos_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_col != '0 && r_cur_line != '0)
        else $error("line or column dropped to zero");

endmodule

[design/stl_outq.sv]
// Result queue: holds the up-to-three tokens of one item and feeds them one
// at a time into the output register. Depends on stl_pkg.
module stl_outq #(
    parameter int TOK_W = 78
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  stl_pkg::t_push_ctl i_push,
    input  logic [TOK_W-1:0]   i_tok [stl_pkg::MAX_RESULTS],
    output logic               o_can_take,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [TOK_W-1:0]   o_tok,
    output logic               o_last
);

    logic [TOK_W-1:0] r_slot [stl_pkg::MAX_RESULTS];
    logic [1:0]       r_cnt;
    logic             r_out_valid;
    logic [TOK_W-1:0] r_out_tok;
    logic             r_out_last;
    logic             pop;

    assign pop        = (r_cnt != 2'd0) && (!r_out_valid || i_ready);
    assign o_can_take = (r_cnt == 2'd0) || (r_cnt == 2'd1 && pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_push.push) begin
                r_cnt <= i_push.count;
            end else if (pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
            if (pop) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_slot <= i_tok;
        end else if (pop) begin
            r_slot[0] <= r_slot[1];
            r_slot[1] <= r_slot[2];
        end
        if (pop) begin
            r_out_tok  <= r_slot[0];
            r_out_last <= (r_cnt == 2'd1);
        end
    end

    assign o_valid = r_out_valid;
    assign o_tok   = r_out_tok;
    assign o_last  = r_out_last;

endmodule

[verif/script_token_lexer_tb.sv]
`timescale 1ns / 100ps
// Self-checking bench for script_token_lexer: streams source bytes, lexes them in a
// local token predictor and checks every token item against it. Depends on stl_pkg and script_token_lexer.
module script_token_lexer_tb;

    localparam int TOK_BITS = stl_pkg::KIND_BITS + 16 + 16 + 24 + 16 + 2;
    localparam int DATA_BITS = TOK_BITS - stl_pkg::KIND_BITS;
    localparam int OUT_BITS = ((DATA_BITS + 7) / 8) * 8;
    localparam int RANDOM_ITEMS = 275;
    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 20;

    // token item: tdata fields above the kind from tuser, lowest field last
    typedef struct packed {
        logic           trail_zero;
        logic           lead_zero;
        logic [15:0]    len;
        logic [23:0]    offs;
        logic [15:0]    col_no;
        logic [15:0]    line_no;
        stl_pkg::t_kind kind;
    } t_lex_token;

    typedef struct {
        t_lex_token tok;
        logic       last;
    } t_token_exp;

    typedef struct {
        logic [7:0]  ch;
        logic        has_byte;
        logic        ends;
        int unsigned gap;
    } t_src_item;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_s_axis_tvalid = 1'b0;
    logic                          o_s_axis_tready;
    logic [7:0]                    i_s_axis_tdata = 8'h00;   // char_byte
    logic                          i_s_axis_tuser = 1'b0;    // char_valid
    logic                          i_s_axis_tlast = 1'b0;    // is_final
    logic                          o_m_axis_tvalid;
    logic                          i_m_axis_tready = 1'b0;
    // line, column, offset, length, leading zero, trailing zero, zero fill
    logic [OUT_BITS-1:0]           o_m_axis_tdata;
    logic [stl_pkg::KIND_BITS-1:0] o_m_axis_tuser;           // token_kind
    logic                          o_m_axis_tlast;           // end_of_run

    script_token_lexer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    t_src_item  source_items[$];
    t_token_exp expected_tokens[$];
    t_lex_token item_tokens[$];

    int unsigned error_count = 0;
    int unsigned tokens_seen = 0;
    int unsigned quiet_cycles = 0;
    int unsigned counted_items = 0;
    int unsigned sink_wait = 0;
    logic        sink_calm = 1'b0;
    logic        calm = 1'b0;

    // lexer state of the predictor
    stl_pkg::t_class cls;
    logic            pt_seen, dig_seen, lead_pt, trail_pt;
    logic [15:0]     cur_line, cur_col, tok_line, tok_col, tok_len;
    logic [23:0]     cur_off, tok_off;

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------------------------------------------------------- predictor

    function automatic logic [15:0] inc16(input logic [15:0] v);
        return (&v) ? v : v + 16'd1;
    endfunction

    function automatic logic [23:0] inc24(input logic [23:0] v);
        return (&v) ? v : v + 24'd1;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    task automatic clear_lexer();
        cls = stl_pkg::CL_IDLE;
        {pt_seen, dig_seen, lead_pt, trail_pt} = 4'b0000;
        cur_line = 16'd1;
        cur_col = 16'd1;
        cur_off = 24'd0;
        tok_line = 16'd1;
        tok_col = 16'd1;
        tok_off = 24'd0;
        tok_len = 16'd0;
    endtask

    task automatic put_token(input stl_pkg::t_kind k, input logic [15:0] ln,
                             input logic [15:0] cn, input logic [23:0] pos,
                             input logic [15:0] len, input logic lz, input logic tz);
        t_lex_token t;
        t.kind = k;
        t.line_no = ln;
        t.col_no = cn;
        t.offs = pos;
        t.len = len;
        t.lead_zero = lz;
        t.trail_zero = tz;
        item_tokens.insert(item_tokens.size(), t);
    endtask

    task automatic step_col();
        cur_col = inc16(cur_col);
        cur_off = inc24(cur_off);
    endtask

    task automatic grow();
        tok_len = inc16(tok_len);
        step_col();
    endtask

    task automatic begin_token(input stl_pkg::t_class c);
        cls = c;
        tok_line = cur_line;
        tok_col = cur_col;
        tok_off = cur_off;
        tok_len = 16'd1;
        step_col();
    endtask

    // two-character operator: take the byte and emit at once
    task automatic pair(input stl_pkg::t_kind k);
        grow();
        put_token(k, tok_line, tok_col, tok_off, tok_len, 1'b0, 1'b0);
        cls = stl_pkg::CL_IDLE;
    endtask

    // emit whatever token is held and drop back to idle
    task automatic close_pending();
        case (cls)
            stl_pkg::CL_ID: put_token(stl_pkg::K_ID, tok_line, tok_col, tok_off, tok_len,
                                      1'b0, 1'b0);
            stl_pkg::CL_NUM: begin
                if (pt_seen && !dig_seen) begin
                    put_token(stl_pkg::K_DOT, tok_line, tok_col, tok_off, tok_len,
                              1'b0, 1'b0);
                end else if (pt_seen) begin
                    put_token(stl_pkg::K_FLOAT, tok_line, tok_col, tok_off, tok_len,
                              lead_pt, !lead_pt && trail_pt);
                end else begin
                    put_token(stl_pkg::K_INT, tok_line, tok_col, tok_off, tok_len,
                              1'b0, 1'b0);
                end
            end
            stl_pkg::CL_PLUS:  put_token(stl_pkg::K_PLUS, tok_line, tok_col, tok_off,
                                         tok_len, 1'b0, 1'b0);
            stl_pkg::CL_MINUS: put_token(stl_pkg::K_MINUS, tok_line, tok_col, tok_off,
                                         tok_len, 1'b0, 1'b0);
            stl_pkg::CL_STAR:  put_token(stl_pkg::K_STAR, tok_line, tok_col, tok_off,
                                         tok_len, 1'b0, 1'b0);
            stl_pkg::CL_SLASH: put_token(stl_pkg::K_SLASH, tok_line, tok_col, tok_off,
                                         tok_len, 1'b0, 1'b0);
            default: ;
        endcase
        cls = stl_pkg::CL_IDLE;
    endtask

    // byte seen with nothing pending that could take it
    task automatic open_token(input logic [7:0] c);
        logic [23:0] at_off;
        if (c == stl_pkg::CH_SPACE || c == stl_pkg::CH_TAB) begin
            step_col();
        end else if (c == stl_pkg::CH_NL) begin
            cur_line = inc16(cur_line);
            cur_col = 16'd1;
            cur_off = inc24(cur_off);
        end else if (is_alpha(c) || c == stl_pkg::CH_USCORE) begin
            begin_token(stl_pkg::CL_ID);
        end else if (is_num(c) || c == stl_pkg::CH_POINT) begin
            begin_token(stl_pkg::CL_NUM);
            pt_seen = (c == stl_pkg::CH_POINT);
            dig_seen = !pt_seen;
            lead_pt = pt_seen;
            trail_pt = pt_seen;
        end else if (c == stl_pkg::CH_PLUS) begin
            begin_token(stl_pkg::CL_PLUS);
        end else if (c == stl_pkg::CH_MINUS) begin
            begin_token(stl_pkg::CL_MINUS);
        end else if (c == stl_pkg::CH_STAR) begin
            begin_token(stl_pkg::CL_STAR);
        end else if (c == stl_pkg::CH_SLASH) begin
            begin_token(stl_pkg::CL_SLASH);
        end else begin
            // invalid byte reports the column after itself
            at_off = cur_off;
            step_col();
            put_token(stl_pkg::K_INVALID, cur_line, cur_col, at_off, 16'd1, 1'b0, 1'b0);
        end
    endtask

    // work out the tokens caused by one accepted source item
    task automatic lex_item(input logic [7:0] c, input logic has_byte, input logic ends);
        logic taken;
        t_token_exp e;
        taken = 1'b0;
        item_tokens.delete();
        if (has_byte) begin
            case (cls)
                stl_pkg::CL_ID: begin
                    if (is_alpha(c) || is_num(c) || c == stl_pkg::CH_USCORE) begin
                        grow();
                        taken = 1'b1;
                    end
                end
                stl_pkg::CL_NUM: begin
                    if (is_num(c)) begin
                        grow();
                        dig_seen = 1'b1;
                        trail_pt = 1'b0;
                        taken = 1'b1;
                    end else if (c == stl_pkg::CH_POINT && !pt_seen) begin
                        grow();
                        pt_seen = 1'b1;
                        trail_pt = 1'b1;
                        taken = 1'b1;
                    end
                end
                stl_pkg::CL_PLUS: begin
                    if (c == stl_pkg::CH_PLUS) begin
                        pair(stl_pkg::K_PLUS2);
                        taken = 1'b1;
                    end else if (c == stl_pkg::CH_EQ) begin
                        pair(stl_pkg::K_PLUSEQ);
                        taken = 1'b1;
                    end
                end
                stl_pkg::CL_MINUS: begin
                    if (c == stl_pkg::CH_MINUS) begin
                        pair(stl_pkg::K_MINUS2);
                        taken = 1'b1;
                    end else if (c == stl_pkg::CH_EQ) begin
                        pair(stl_pkg::K_MINUSEQ);
                        taken = 1'b1;
                    end
                end
                stl_pkg::CL_STAR: begin
                    if (c == stl_pkg::CH_EQ) begin
                        pair(stl_pkg::K_STAREQ);
                        taken = 1'b1;
                    end
                end
                stl_pkg::CL_SLASH: begin
                    if (c == stl_pkg::CH_EQ) begin
                        pair(stl_pkg::K_SLASHEQ);
                        taken = 1'b1;
                    end
                end
                default: ;
            endcase
            if (!taken) begin
                close_pending();
                open_token(c);
            end
        end
        if (ends) begin
            close_pending();
            put_token(stl_pkg::K_END, cur_line, cur_col, cur_off, 16'd0, 1'b0, 1'b0);
            clear_lexer();
        end
        foreach (item_tokens[i]) begin
            e.tok = item_tokens[i];
            e.last = (i == item_tokens.size() - 1);
            expected_tokens.insert(expected_tokens.size(), e);
        end
    endtask

    // ---------------------------------------------------------------- stimulus

    // mostly short gaps, now and then a long one
    function automatic int unsigned draw_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic add_item(input logic [7:0] c, input logic has_byte, input logic ends);
        t_src_item s;
        s.ch = c;
        s.has_byte = has_byte;
        s.ends = ends;
        s.gap = calm ? 0 : draw_gap();
        source_items.insert(source_items.size(), s);
        if (has_byte || ends) counted_items++;
    endtask

    task automatic add_text(input string s);
        foreach (s[i]) add_item(s[i], 1'b1, 1'b0);
    endtask

    function automatic logic [7:0] any_letter();
        return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] any_digit();
        return 8'h30 + 8'($urandom_range(0, 9));
    endfunction

    task automatic add_digits(input int unsigned n);
        repeat (n) add_item(any_digit(), 1'b1, 1'b0);
    endtask

    // one random lexeme, well formed most of the time
    task automatic add_word();
        logic [7:0] c;
        int unsigned form;
        case ($urandom_range(0, 15))
            0, 1, 2: begin
                add_item(($urandom_range(0, 5) == 0) ? stl_pkg::CH_USCORE : any_letter(),
                         1'b1, 1'b0);
                repeat ($urandom_range(0, 5)) begin
                    form = $urandom_range(0, 2);
                    c = (form == 0) ? any_letter() : (form == 1) ? any_digit()
                        : stl_pkg::CH_USCORE;
                    add_item(c, 1'b1, 1'b0);
                end
            end
            3, 4: add_digits($urandom_range(1, 4));
            5, 6: begin
                form = $urandom_range(0, 4);
                if (form != 0 && form != 4) add_digits($urandom_range(1, 3));
                add_item(stl_pkg::CH_POINT, 1'b1, 1'b0);
                if (form == 0 || form == 2 || form == 3) add_digits($urandom_range(1, 3));
                if (form == 3) add_item(stl_pkg::CH_POINT, 1'b1, 1'b0);
            end
            7, 8, 9: begin
                case ($urandom_range(0, 3))
                    0: c = stl_pkg::CH_PLUS;
                    1: c = stl_pkg::CH_MINUS;
                    2: c = stl_pkg::CH_STAR;
                    default: c = stl_pkg::CH_SLASH;
                endcase
                add_item(c, 1'b1, 1'b0);
                form = $urandom_range(0, 2);
                if (form == 1) add_item(stl_pkg::CH_EQ, 1'b1, 1'b0);
                if (form == 2) add_item(c, 1'b1, 1'b0);
            end
            10: add_item($urandom_range(0, 1) ? stl_pkg::CH_SPACE : stl_pkg::CH_TAB,
                         1'b1, 1'b0);
            11: add_item(stl_pkg::CH_NL, 1'b1, 1'b0);
            12: begin
                // a byte that no token class takes
                do c = 8'($urandom);
                while (is_alpha(c) || is_num(c) || c inside {stl_pkg::CH_USCORE,
                       stl_pkg::CH_POINT, stl_pkg::CH_PLUS, stl_pkg::CH_MINUS,
                       stl_pkg::CH_STAR, stl_pkg::CH_SLASH, stl_pkg::CH_SPACE,
                       stl_pkg::CH_TAB, stl_pkg::CH_NL});
                add_item(c, 1'b1, 1'b0);
            end
            13: add_item(8'($urandom), 1'b1, 1'b0);
            14: add_item(8'($urandom), 1'b0, 1'b0);
            default: add_item(8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
        endcase
    endtask

    initial begin
        clear_lexer();

        // every token kind, float zero flags, a lone dot, then int + invalid + end at once
        add_text("_9 .5\n7..+++=---=*=*/=/-\t+4");
        add_item(8'hFF, 1'b1, 1'b1);
        add_item(8'h5A, 1'b0, 1'b0);
        add_text("Az");
        add_item(8'h0D, 1'b1, 1'b0);
        add_item(8'h80, 1'b1, 1'b0);
        add_item(8'h00, 1'b0, 1'b1);

        counted_items = 0;
        while (counted_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 19) == 0) calm = !calm;
            add_word();
        end
        add_item(8'($urandom), 1'b0, 1'b1);

        while (!i_rst_n) @(negedge i_clk);
        while (source_items.size() != 0 || i_s_axis_tvalid) @(negedge i_clk);
        while (expected_tokens.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // ---------------------------------------------------------------- driver

    always @(posedge i_clk) begin
        t_src_item nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata <= 8'h00;
            i_s_axis_tuser <= 1'b0;
            i_s_axis_tlast <= 1'b0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                lex_item(i_s_axis_tdata, i_s_axis_tuser, i_s_axis_tlast);
            // advance only when the current item is gone or none is offered
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (source_items.size() != 0 && source_items[0].gap != 0) begin
                    source_items[0].gap = source_items[0].gap - 1;
                    i_s_axis_tvalid <= 1'b0;
                end else if (source_items.size() != 0) begin
                    nxt = source_items.pop_front();
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= nxt.ch;
                    i_s_axis_tuser <= nxt.has_byte;
                    i_s_axis_tlast <= nxt.ends;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------------------------------------------------------- monitor

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("token %0d: %s is 0x%0h, expected 0x%0h", tokens_seen, what, got, want);
        error_count++;
    endtask

    always @(posedge i_clk) begin
        t_lex_token got;
        t_token_exp want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            sink_wait <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_lex_token'({o_m_axis_tdata[DATA_BITS-1:0], o_m_axis_tuser});
                if (expected_tokens.size() == 0) begin
                    flag_mismatch("token with none expected, kind", got.kind,
                                  stl_pkg::K_END);
                end else begin
                    want = expected_tokens.pop_front();
                    if (got.kind != want.tok.kind)
                        flag_mismatch("kind", got.kind, want.tok.kind);
                    if (got.line_no != want.tok.line_no)
                        flag_mismatch("start line", got.line_no, want.tok.line_no);
                    if (got.col_no != want.tok.col_no)
                        flag_mismatch("start column", got.col_no, want.tok.col_no);
                    if (got.offs != want.tok.offs)
                        flag_mismatch("start offset", got.offs, want.tok.offs);
                    if (got.len != want.tok.len)
                        flag_mismatch("length", got.len, want.tok.len);
                    if (got.lead_zero != want.tok.lead_zero)
                        flag_mismatch("leading zero", got.lead_zero, want.tok.lead_zero);
                    if (got.trail_zero != want.tok.trail_zero)
                        flag_mismatch("trailing zero", got.trail_zero, want.tok.trail_zero);
                    if (o_m_axis_tdata[OUT_BITS-1:DATA_BITS] != '0)
                        flag_mismatch("fill bits", o_m_axis_tdata[OUT_BITS-1:DATA_BITS], 0);
                    if (o_m_axis_tlast != want.last)
                        flag_mismatch("end of run", o_m_axis_tlast, want.last);
                end
                tokens_seen++;
            end
            // receiver stalls, with calm stretches in between
            if ($urandom_range(0, 299) == 0) sink_calm <= !sink_calm;
            if (sink_wait != 0) begin
                i_m_axis_tready <= 1'b0;
                sink_wait <= sink_wait - 1;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (!sink_calm && $urandom_range(0, 3) == 0) sink_wait <= draw_gap();
            end
        end
    end

    // ---------------------------------------------------------------- watchdog

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("stalled for %0d cycles, %0d tokens still expected", QUIET_LIMIT,
                     expected_tokens.size());
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
